// ===== rtl/packet_timing_stats_accumulator_defines.svh =====
// Assertion macros shared by the packet timing statistics RTL.
`ifndef PACKET_TIMING_STATS_ACCUMULATOR_DEFINES_SVH
`define PACKET_TIMING_STATS_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pts assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pts assertion failed");

`endif

// ===== rtl/pts_pkg.sv =====
// Shared types and constants for the packet timing statistics accumulator.
`timescale 1ns / 1ps

package pts_pkg;

	// Number of statistics groups and the width of a group code
	localparam int NUM_GROUPS = 4;
	localparam int GRP_W      = 2;

	// Fixed result widths
	localparam int OUT_VAL_W   = 49;
	localparam int POS_W       = 32;
	localparam int LOST_W      = 48;
	localparam int FIRST_OUT_W = 48;
	localparam int SUM_W       = 64;
	localparam int SQ_W        = 64;
	localparam int SQ_MAG_W    = 32;

	// Smallest signed width that holds the size minimum reset as a positive value
	localparam int SIZE_VAL_W = 33;

	// Reset minimum of the size group
	localparam logic [31:0] SIZE_MIN_RESET = 32'hFFFF_FFFF;

	// Saturation limits of the signed sum
	localparam logic [SUM_W-1:0] SUM_POS_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_NEG_LIMIT = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic {
		CMD_RECORD = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	typedef enum logic [GRP_W-1:0] {
		GRP_SEND_GAP = 2'd0,
		GRP_RECV_GAP = 2'd1,
		GRP_DELAY    = 2'd2,
		GRP_SIZE     = 2'd3
	} grp_t;

	// Per-group sample control: take the sample, and whether it may set the minimum
	typedef struct packed {
		logic en;
		logic allow_min;
	} smp_ctl_t;

endpackage

// ===== rtl/packet_timing_stats_accumulator.sv =====
// Top level of the packet timing statistics accumulator.
// A read's result is loaded into the result register after the read passes stages 1, 2 and 3.
// Throughput: one item per cycle, unless a read in stage 3 waits for the result slot.
// Records give no result; records without a send time are dropped at the input.
// Reset: asynchronous, clears all statistics to their initial values and empties the pipe.
`timescale 1ns / 1ps
`include "packet_timing_stats_accumulator_defines.svh"

module packet_timing_stats_accumulator import pts_pkg::*; #(
	parameter int TIME_BITS  = 48,
	parameter int SIZE_BITS  = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic                        command,
	input  logic [GRP_W-1:0]            group_select,
	input  logic [TIME_BITS-1:0]        send_time,
	input  logic                        send_present,
	input  logic [TIME_BITS-1:0]        receive_time,
	input  logic                        receive_present,
	input  logic signed [TIME_BITS-1:0] one_way_delay,
	input  logic [SIZE_BITS-1:0]        packet_size,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [GRP_W-1:0]            group_id,
	output logic signed [OUT_VAL_W-1:0] min_value,
	output logic signed [OUT_VAL_W-1:0] max_value,
	output logic [POS_W-1:0]            min_position,
	output logic [POS_W-1:0]            max_position,
	output logic signed [SUM_W-1:0]     value_sum,
	output logic [SQ_W-1:0]             square_sum,
	output logic [POS_W-1:0]            packets_sent,
	output logic [POS_W-1:0]            packets_received,
	output logic [LOST_W-1:0]           bytes_lost,
	output logic [FIRST_OUT_W-1:0]      first_send_time
);

	localparam int VAL_W = (TIME_BITS + 1 > SIZE_VAL_W) ? TIME_BITS + 1 : SIZE_VAL_W;
	localparam logic signed [VAL_W-1:0] TIME_MIN_RST = VAL_W'({TIME_BITS{1'b1}});
	localparam logic signed [VAL_W-1:0] TIME_MAX_RST = ~TIME_MIN_RST;
	localparam logic signed [VAL_W-1:0] SIZE_MIN_RST = VAL_W'(SIZE_MIN_RESET);
	localparam logic signed [VAL_W-1:0] SIZE_MAX_RST = '0;

	// Stage 1: input register
	logic                        valid_s1;
	logic                        rd_s1;
	grp_t                        grp_s1;
	logic [TIME_BITS-1:0]        send_time_s1;
	logic [TIME_BITS-1:0]        recv_time_s1;
	logic                        recv_s1;
	logic signed [TIME_BITS-1:0] delay_s1;
	logic [SIZE_BITS-1:0]        size_s1;

	// Stage 2: samples and counter snapshot
	logic                        valid_s2;
	logic                        rd_s2;
	grp_t                        grp_s2;
	logic signed [VAL_W-1:0]     val_s2 [NUM_GROUPS];
	smp_ctl_t                    ctl_s2 [NUM_GROUPS];
	logic [COUNT_BITS-1:0]       pos_s2;
	logic [COUNT_BITS-1:0]       sent_s2;
	logic [COUNT_BITS-1:0]       recvd_s2;
	logic [LOST_W-1:0]           lost_s2;
	logic [TIME_BITS-1:0]        first_s2;

	// Stage 3: samples with squares
	logic                        valid_s3;
	logic                        rd_s3;
	grp_t                        grp_s3;
	logic signed [VAL_W-1:0]     val_s3 [NUM_GROUPS];
	smp_ctl_t                    ctl_s3 [NUM_GROUPS];
	logic [SQ_W-1:0]             sq_s3 [NUM_GROUPS];
	logic [COUNT_BITS-1:0]       pos_s3;
	logic [COUNT_BITS-1:0]       sent_s3;
	logic [COUNT_BITS-1:0]       recvd_s3;
	logic [LOST_W-1:0]           lost_s3;
	logic [TIME_BITS-1:0]        first_s3;

	// Result register
	logic                        result_valid_q;
	logic [GRP_W-1:0]            group_id_q;
	logic signed [OUT_VAL_W-1:0] min_value_q;
	logic signed [OUT_VAL_W-1:0] max_value_q;
	logic [POS_W-1:0]            min_pos_q;
	logic [POS_W-1:0]            max_pos_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic [SQ_W-1:0]             sq_sum_q;
	logic [POS_W-1:0]            sent_q;
	logic [POS_W-1:0]            recvd_q;
	logic [LOST_W-1:0]           lost_q;
	logic [FIRST_OUT_W-1:0]      first_q;

	// Front end outputs
	logic signed [VAL_W-1:0]     smp_val [NUM_GROUPS];
	smp_ctl_t                    smp_ctl [NUM_GROUPS];
	logic [COUNT_BITS-1:0]       smp_pos;
	logic [COUNT_BITS-1:0]       cnt_sent;
	logic [COUNT_BITS-1:0]       cnt_recv;
	logic [LOST_W-1:0]           cnt_lost;
	logic [TIME_BITS-1:0]        cnt_first;

	// Square and group outputs
	logic [SQ_W-1:0]             sq_next [NUM_GROUPS];
	smp_ctl_t                    grp_ctl [NUM_GROUPS];
	logic signed [VAL_W-1:0]     grp_min [NUM_GROUPS];
	logic signed [VAL_W-1:0]     grp_max [NUM_GROUPS];
	logic [COUNT_BITS-1:0]       grp_min_pos [NUM_GROUPS];
	logic [COUNT_BITS-1:0]       grp_max_pos [NUM_GROUPS];
	logic signed [SUM_W-1:0]     grp_sum [NUM_GROUPS];
	logic [SQ_W-1:0]             grp_sq_sum [NUM_GROUPS];

	// Pipeline flow control
	logic move_s1;
	logic move_s2;
	logic move_s3;
	logic free_s2;
	logic free_s3;
	logic rec_commit;

	// A record in stage 3 always retires; a read waits for the result slot
	assign move_s3    = valid_s3 && (!rd_s3 || !result_valid_q || result_ready);
	assign free_s3    = !valid_s3 || move_s3;
	assign move_s2    = valid_s2 && free_s3;
	assign free_s2    = !valid_s2 || move_s2;
	assign move_s1    = valid_s1 && free_s2;
	assign item_ready = !valid_s1 || move_s1;
	assign rec_commit = move_s3 && !rd_s3;

	// Stage valids: stage 1 drops records that carry no send time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid && ((command == CMD_READ) || send_present);
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (free_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Capture the input item
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			rd_s1        <= (command == CMD_READ);
			grp_s1       <= grp_t'(group_select);
			send_time_s1 <= send_time;
			recv_time_s1 <= receive_time;
			recv_s1      <= receive_present;
			delay_s1     <= one_way_delay;
			size_s1      <= packet_size;
		end
	end

	pts_front #(
		.TIME_BITS  (TIME_BITS),
		.SIZE_BITS  (SIZE_BITS),
		.COUNT_BITS (COUNT_BITS),
		.VAL_W      (VAL_W)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (move_s1 && !rd_s1),
		.send_time       (send_time_s1),
		.receive_time    (recv_time_s1),
		.receive_present (recv_s1),
		.one_way_delay   (delay_s1),
		.packet_size     (size_s1),
		.sample          (smp_val),
		.ctl             (smp_ctl),
		.pos             (smp_pos),
		.sent_cnt        (cnt_sent),
		.recv_cnt        (cnt_recv),
		.lost_bytes      (cnt_lost),
		.first_stamp     (cnt_first)
	);

	// Hold samples and the counter snapshot in stage 2
	always_ff @(posedge clk) begin
		if (move_s1) begin
			rd_s2    <= rd_s1;
			grp_s2   <= grp_s1;
			val_s2   <= smp_val;
			ctl_s2   <= smp_ctl;
			pos_s2   <= smp_pos;
			sent_s2  <= cnt_sent;
			recvd_s2 <= cnt_recv;
			lost_s2  <= cnt_lost;
			first_s2 <= cnt_first;
		end
	end

	// Square each lane and accumulate each group
	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_lane
		pts_square #(
			.VAL_W (VAL_W)
		) u_square (
			.val (val_s2[g]),
			.sq  (sq_next[g])
		);

		assign grp_ctl[g] = '{en: ctl_s3[g].en && rec_commit, allow_min: ctl_s3[g].allow_min};

		pts_group #(
			.VAL_W      (VAL_W),
			.COUNT_BITS (COUNT_BITS),
			.MIN_RESET  ((g == int'(GRP_SIZE)) ? SIZE_MIN_RST : TIME_MIN_RST),
			.MAX_RESET  ((g == int'(GRP_SIZE)) ? SIZE_MAX_RST : TIME_MAX_RST)
		) u_group (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (grp_ctl[g]),
			.val     (val_s3[g]),
			.sq      (sq_s3[g]),
			.pos     (pos_s3),
			.min_val (grp_min[g]),
			.max_val (grp_max[g]),
			.min_pos (grp_min_pos[g]),
			.max_pos (grp_max_pos[g]),
			.sum     (grp_sum[g]),
			.sq_sum  (grp_sq_sum[g])
		);
	end

	// Hold samples and squares in stage 3
	always_ff @(posedge clk) begin
		if (move_s2) begin
			rd_s3    <= rd_s2;
			grp_s3   <= grp_s2;
			val_s3   <= val_s2;
			ctl_s3   <= ctl_s2;
			sq_s3    <= sq_next;
			pos_s3   <= pos_s2;
			sent_s3  <= sent_s2;
			recvd_s3 <= recvd_s2;
			lost_s3  <= lost_s2;
			first_s3 <= first_s2;
		end
	end

	// Result valid: set on a read leaving stage 3, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (move_s3 && rd_s3) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Load the selected group's figures
	always_ff @(posedge clk) begin
		if (move_s3 && rd_s3) begin
			group_id_q  <= grp_s3;
			min_value_q <= OUT_VAL_W'(grp_min[grp_s3]);
			max_value_q <= OUT_VAL_W'(grp_max[grp_s3]);
			min_pos_q   <= POS_W'(grp_min_pos[grp_s3]);
			max_pos_q   <= POS_W'(grp_max_pos[grp_s3]);
			sum_q       <= grp_sum[grp_s3];
			sq_sum_q    <= grp_sq_sum[grp_s3];
			sent_q      <= POS_W'(sent_s3);
			recvd_q     <= POS_W'(recvd_s3);
			lost_q      <= lost_s3;
			first_q     <= FIRST_OUT_W'(first_s3);
		end
	end

	assign result_valid     = result_valid_q;
	assign group_id         = group_id_q;
	assign min_value        = min_value_q;
	assign max_value        = max_value_q;
	assign min_position     = min_pos_q;
	assign max_position     = max_pos_q;
	assign value_sum        = sum_q;
	assign square_sum       = sq_sum_q;
	assign packets_sent     = sent_q;
	assign packets_received = recvd_q;
	assign bytes_lost       = lost_q;
	assign first_send_time  = first_q;

	`PTS_ASSERT_NEXT(a_read_held, clk, arst_n, valid_s3 && rd_s3 && result_valid_q && !result_ready, valid_s3 && rd_s3)
	`PTS_ASSERT_NEXT(a_read_result, clk, arst_n, move_s3 && rd_s3, result_valid_q && (group_id_q == $past(grp_s3)))
	`PTS_ASSERT_NEXT(a_read_enters, clk, arst_n, item_valid && item_ready && (command == CMD_READ), valid_s1 && rd_s1)

endmodule

// ===== rtl/pts_front.sv =====
// Record front end: timestamp gaps, packet counters and lost byte total.
`timescale 1ns / 1ps

module pts_front import pts_pkg::*; #(
	parameter int TIME_BITS  = 48,
	parameter int SIZE_BITS  = 16,
	parameter int COUNT_BITS = 32,
	parameter int VAL_W      = 49
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [TIME_BITS-1:0]         send_time,
	input  logic [TIME_BITS-1:0]         receive_time,
	input  logic                         receive_present,
	input  logic signed [TIME_BITS-1:0]  one_way_delay,
	input  logic [SIZE_BITS-1:0]         packet_size,
	output logic signed [VAL_W-1:0]      sample [NUM_GROUPS],
	output smp_ctl_t                     ctl [NUM_GROUPS],
	output logic [COUNT_BITS-1:0]        pos,
	output logic [COUNT_BITS-1:0]        sent_cnt,
	output logic [COUNT_BITS-1:0]        recv_cnt,
	output logic [LOST_W-1:0]            lost_bytes,
	output logic [TIME_BITS-1:0]         first_stamp
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [TIME_BITS-1:0]     last_send_q;
	logic                     last_send_seen_q;
	logic [TIME_BITS-1:0]     last_recv_q;
	logic                     last_recv_seen_q;
	logic [TIME_BITS-1:0]     first_q;
	logic [COUNT_BITS-1:0]    sent_q;
	logic [COUNT_BITS-1:0]    recv_q;
	logic [LOST_W-1:0]        lost_q;

	logic signed [TIME_BITS:0] gap_send;
	logic signed [TIME_BITS:0] gap_recv;
	logic [COUNT_BITS-1:0]     sent_next;
	logic [COUNT_BITS-1:0]     recv_next;
	logic [LOST_W:0]           lost_sum;
	logic [LOST_W-1:0]         lost_next;

	// Form the signed gaps against the previous timestamps
	assign gap_send = $signed({1'b0, send_time}) - $signed({1'b0, last_send_q});
	assign gap_recv = $signed({1'b0, receive_time}) - $signed({1'b0, last_recv_q});

	// Saturate the counters and the lost byte total
	assign sent_next = (sent_q == COUNT_MAX) ? sent_q : sent_q + 1'b1;
	assign recv_next = (recv_q == COUNT_MAX) ? recv_q : recv_q + 1'b1;
	assign lost_sum  = {1'b0, lost_q} + (LOST_W+1)'(packet_size);
	assign lost_next = lost_sum[LOST_W] ? {LOST_W{1'b1}} : lost_sum[LOST_W-1:0];

	// Position of this packet once counted
	assign pos = sent_next - 1'b1;

	// Build the four group samples and their enables
	always_comb begin
		sample[GRP_SEND_GAP] = VAL_W'(gap_send);
		sample[GRP_RECV_GAP] = VAL_W'(gap_recv);
		sample[GRP_DELAY]    = VAL_W'(one_way_delay);
		sample[GRP_SIZE]     = VAL_W'(packet_size);
		ctl[GRP_SEND_GAP]    = '{en: last_send_seen_q, allow_min: 1'b1};
		ctl[GRP_RECV_GAP]    = '{en: receive_present && last_recv_seen_q,
			allow_min: !gap_recv[TIME_BITS]};
		ctl[GRP_DELAY]       = '{en: receive_present, allow_min: 1'b1};
		ctl[GRP_SIZE]        = '{en: 1'b1, allow_min: 1'b1};
	end

	// Advance the bookkeeping state on each record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_send_q      <= '0;
			last_send_seen_q <= 1'b0;
			last_recv_q      <= '0;
			last_recv_seen_q <= 1'b0;
			first_q          <= '0;
			sent_q           <= '0;
			recv_q           <= '0;
			lost_q           <= '0;
		end else if (adv) begin
			sent_q           <= sent_next;
			last_send_q      <= send_time;
			last_send_seen_q <= 1'b1;
			if (!last_send_seen_q) begin
				first_q <= send_time;
			end
			if (receive_present) begin
				last_recv_q      <= receive_time;
				last_recv_seen_q <= 1'b1;
				recv_q           <= recv_next;
			end else begin
				lost_q <= lost_next;
			end
		end
	end

	assign sent_cnt    = sent_q;
	assign recv_cnt    = recv_q;
	assign lost_bytes  = lost_q;
	assign first_stamp = first_q;

endmodule

// ===== rtl/pts_square.sv =====
// Saturating square of one signed group sample.
`timescale 1ns / 1ps

module pts_square import pts_pkg::*; #(
	parameter int VAL_W = 49
) (
	input  logic signed [VAL_W-1:0] val,
	output logic [SQ_W-1:0]         sq
);

	logic [VAL_W-1:0] mag;
	logic             big;

	// Take the magnitude; anything at or above 2^32 squares past the limit
	assign mag = val[VAL_W-1] ? VAL_W'(-val) : VAL_W'(val);
	assign big = |mag[VAL_W-1:SQ_MAG_W];

	assign sq = big ? {SQ_W{1'b1}}
		: SQ_W'(mag[SQ_MAG_W-1:0]) * SQ_W'(mag[SQ_MAG_W-1:0]);

endmodule

// ===== rtl/pts_group.sv =====
// One statistics group: min, max, their positions, saturating sum and square sum.
`timescale 1ns / 1ps
`include "packet_timing_stats_accumulator_defines.svh"

module pts_group import pts_pkg::*; #(
	parameter int                     VAL_W      = 49,
	parameter int                     COUNT_BITS = 32,
	parameter logic signed [VAL_W-1:0] MIN_RESET = '0,
	parameter logic signed [VAL_W-1:0] MAX_RESET = '0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  smp_ctl_t                ctl,
	input  logic signed [VAL_W-1:0] val,
	input  logic [SQ_W-1:0]         sq,
	input  logic [COUNT_BITS-1:0]   pos,
	output logic signed [VAL_W-1:0] min_val,
	output logic signed [VAL_W-1:0] max_val,
	output logic [COUNT_BITS-1:0]   min_pos,
	output logic [COUNT_BITS-1:0]   max_pos,
	output logic signed [SUM_W-1:0] sum,
	output logic [SQ_W-1:0]         sq_sum
);

	logic signed [VAL_W-1:0]  min_q;
	logic signed [VAL_W-1:0]  max_q;
	logic [COUNT_BITS-1:0]    min_pos_q;
	logic [COUNT_BITS-1:0]    max_pos_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]          sq_sum_q;

	logic signed [SUM_W:0]    sum_ext;
	logic signed [SUM_W-1:0]  sum_next;
	logic [SQ_W:0]            sq_ext;
	logic [SQ_W-1:0]          sq_next;
	logic                     new_min;
	logic                     new_max;

	// Saturate the signed sum on overflow in either direction
	assign sum_ext = $signed({sum_q[SUM_W-1], sum_q}) + (SUM_W+1)'(val);
	always_comb begin
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_next = sum_ext[SUM_W] ? SUM_NEG_LIMIT : SUM_POS_LIMIT;
		end else begin
			sum_next = sum_ext[SUM_W-1:0];
		end
	end

	// Saturate the square sum on carry out
	assign sq_ext  = {1'b0, sq_sum_q} + {1'b0, sq};
	assign sq_next = sq_ext[SQ_W] ? {SQ_W{1'b1}} : sq_ext[SQ_W-1:0];

	// Update extremes only on strictly smaller or larger values
	assign new_min = ctl.allow_min && (val < min_q);
	assign new_max = val > max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q     <= MIN_RESET;
			max_q     <= MAX_RESET;
			min_pos_q <= '0;
			max_pos_q <= '0;
			sum_q     <= '0;
			sq_sum_q  <= '0;
		end else if (ctl.en) begin
			sum_q    <= sum_next;
			sq_sum_q <= sq_next;
			if (new_min) begin
				min_q     <= val;
				min_pos_q <= pos;
			end
			if (new_max) begin
				max_q     <= val;
				max_pos_q <= pos;
			end
		end
	end

	assign min_val = min_q;
	assign max_val = max_q;
	assign min_pos = min_pos_q;
	assign max_pos = max_pos_q;
	assign sum     = sum_q;
	assign sq_sum  = sq_sum_q;

	`PTS_ASSERT_NEXT(a_sq_sum_monotone, clk, arst_n, 1'b1, sq_sum_q >= $past(sq_sum_q))
	`PTS_ASSERT_NEXT(a_min_blocked, clk, arst_n, ctl.en && !ctl.allow_min, $stable(min_q))
	`PTS_ASSERT_NEXT(a_idle_hold, clk, arst_n, !ctl.en, $stable(sum_q) && $stable(sq_sum_q))

endmodule

// ===== tb/packet_timing_stats_accumulator_tb.sv =====
// Self-checking testbench for the packet timing statistics accumulator.
`timescale 1ns / 1ps

module packet_timing_stats_accumulator_tb;
	import pts_pkg::*;

	localparam int TS_W  = 48;
	localparam int SZ_W  = 16;
	localparam int CNT_W = 32;

	localparam logic [TS_W-1:0]         TS_MAX  = 48'hFFFF_FFFF_FFFF;
	localparam logic signed [TS_W-1:0]  DLY_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [TS_W-1:0]  DLY_MIN = 48'sh8000_0000_0000;
	localparam logic signed [63:0]      TS_TOP  = 64'sh0000_FFFF_FFFF_FFFF;
	localparam logic signed [63:0]      TS_BOT  = 64'shFFFF_0000_0000_0000;

	localparam int RAND_ITEMS   = 1250;
	localparam int WILD_FROM    = 950;
	localparam int FLOOD_AT     = 400;
	localparam int FLOOD_ITEMS  = 80;
	localparam int PAUSE_AT     = 700;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = 20;

	typedef struct packed {
		cmd_t                    command;
		grp_t                    group_select;
		logic [TS_W-1:0]         send_time;
		logic                    send_present;
		logic [TS_W-1:0]         receive_time;
		logic                    receive_present;
		logic signed [TS_W-1:0]  one_way_delay;
		logic [SZ_W-1:0]         packet_size;
	} pkt_rec_t;

	typedef struct packed {
		logic [GRP_W-1:0]            group_id;
		logic signed [OUT_VAL_W-1:0] min_value;
		logic signed [OUT_VAL_W-1:0] max_value;
		logic [POS_W-1:0]            min_position;
		logic [POS_W-1:0]            max_position;
		logic signed [SUM_W-1:0]     value_sum;
		logic [SQ_W-1:0]             square_sum;
		logic [POS_W-1:0]            packets_sent;
		logic [POS_W-1:0]            packets_received;
		logic [LOST_W-1:0]           bytes_lost;
		logic [FIRST_OUT_W-1:0]      first_send_time;
	} stats_rd_t;

	typedef struct packed {
		pkt_rec_t  item;
		bit        typed;
		stats_rd_t want;
	} dir_row_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        item_valid = 1'b0;
	logic                        item_ready;
	logic                        command = 1'b0;
	logic [GRP_W-1:0]            group_select = '0;
	logic [TS_W-1:0]             send_time = '0;
	logic                        send_present = 1'b0;
	logic [TS_W-1:0]             receive_time = '0;
	logic                        receive_present = 1'b0;
	logic signed [TS_W-1:0]      one_way_delay = '0;
	logic [SZ_W-1:0]             packet_size = '0;
	logic                        result_valid;
	logic                        result_ready = 1'b0;
	logic [GRP_W-1:0]            group_id;
	logic signed [OUT_VAL_W-1:0] min_value;
	logic signed [OUT_VAL_W-1:0] max_value;
	logic [POS_W-1:0]            min_position;
	logic [POS_W-1:0]            max_position;
	logic signed [SUM_W-1:0]     value_sum;
	logic [SQ_W-1:0]             square_sum;
	logic [POS_W-1:0]            packets_sent;
	logic [POS_W-1:0]            packets_received;
	logic [LOST_W-1:0]           bytes_lost;
	logic [FIRST_OUT_W-1:0]      first_send_time;

	// Predicted statistics state
	logic [TS_W-1:0]     prev_snd_ts;
	logic                prev_snd_ok;
	logic [TS_W-1:0]     prev_rcv_ts;
	logic                prev_rcv_ok;
	logic [TS_W-1:0]     first_snd_ts;
	logic signed [63:0]  lo_val [NUM_GROUPS];
	logic signed [63:0]  hi_val [NUM_GROUPS];
	logic [CNT_W-1:0]    lo_pos [NUM_GROUPS];
	logic [CNT_W-1:0]    hi_pos [NUM_GROUPS];
	logic signed [63:0]  tot    [NUM_GROUPS];
	logic [63:0]         sq_tot [NUM_GROUPS];
	logic [CNT_W-1:0]    n_sent;
	logic [CNT_W-1:0]    n_recv;
	logic [LOST_W-1:0]   lost_bytes;

	stats_rd_t pending_reads [$];
	dir_row_t  dir_rows [$];
	int        mismatches = 0;
	bit        hold_req = 1'b0;

	packet_timing_stats_accumulator #(
		.TIME_BITS (TS_W),
		.SIZE_BITS (SZ_W),
		.COUNT_BITS(CNT_W)
	) dut (.*);

	// Fold one sample into a group: saturating sums, strict min and max
	function automatic void stats_fold(grp_t g, logic signed [63:0] v, bit allow_lo,
			logic [CNT_W-1:0] pos);
		logic [63:0]        mag;
		logic [63:0]        sq;
		logic [64:0]        s;
		logic [64:0]        u;
		mag = v[63] ? (64'd0 - v) : v;
		sq = (mag >= 64'h1_0000_0000) ? '1 : mag * mag;
		s = {tot[g][63], tot[g]} + {v[63], v};
		if (s[64:63] == 2'b01)
			tot[g] = SUM_POS_LIMIT;
		else if (s[64:63] == 2'b10)
			tot[g] = SUM_NEG_LIMIT;
		else
			tot[g] = s[63:0];
		u = {1'b0, sq_tot[g]} + {1'b0, sq};
		sq_tot[g] = u[64] ? '1 : u[63:0];
		if (allow_lo && v < lo_val[g]) begin
			lo_val[g] = v;
			lo_pos[g] = pos;
		end
		if (v > hi_val[g]) begin
			hi_val[g] = v;
			hi_pos[g] = pos;
		end
	endfunction

	// Advance the predicted state by one item; return 1 when a read result is due
	function automatic bit stats_apply(input pkt_rec_t it, output stats_rd_t rd);
		logic signed [63:0] gap;
		logic signed [63:0] dly;
		logic [CNT_W-1:0]   pos;
		logic [LOST_W:0]    lsum;
		rd = '0;
		if (it.command == CMD_READ) begin
			rd.group_id         = it.group_select;
			rd.min_value        = lo_val[it.group_select][OUT_VAL_W-1:0];
			rd.max_value        = hi_val[it.group_select][OUT_VAL_W-1:0];
			rd.min_position     = lo_pos[it.group_select];
			rd.max_position     = hi_pos[it.group_select];
			rd.value_sum        = tot[it.group_select];
			rd.square_sum       = sq_tot[it.group_select];
			rd.packets_sent     = n_sent;
			rd.packets_received = n_recv;
			rd.bytes_lost       = lost_bytes;
			rd.first_send_time  = first_snd_ts;
			return 1'b1;
		end
		if (!it.send_present)
			return 1'b0;
		if (n_sent != '1)
			n_sent++;
		pos = n_sent - 1'b1;
		if (!prev_snd_ok) begin
			first_snd_ts = it.send_time;
		end else begin
			gap = $signed({16'b0, it.send_time}) - $signed({16'b0, prev_snd_ts});
			stats_fold(GRP_SEND_GAP, gap, 1'b1, pos);
		end
		prev_snd_ts = it.send_time;
		prev_snd_ok = 1'b1;
		stats_fold(GRP_SIZE, $signed({48'b0, it.packet_size}), 1'b1, pos);
		if (it.receive_present) begin
			if (prev_rcv_ok) begin
				gap = $signed({16'b0, it.receive_time}) - $signed({16'b0, prev_rcv_ts});
				// a negative receive gap may raise the max but never sets the min
				stats_fold(GRP_RECV_GAP, gap, !gap[63], pos);
			end
			prev_rcv_ts = it.receive_time;
			prev_rcv_ok = 1'b1;
			if (n_recv != '1)
				n_recv++;
			dly = {{(64-TS_W){it.one_way_delay[TS_W-1]}}, it.one_way_delay};
			stats_fold(GRP_DELAY, dly, 1'b1, pos);
		end else begin
			lsum = {1'b0, lost_bytes} + (LOST_W+1)'(it.packet_size);
			lost_bytes = lsum[LOST_W] ? '1 : lsum[LOST_W-1:0];
		end
		return 1'b0;
	endfunction

	// Figures of a group that has never taken a sample
	function automatic stats_rd_t fresh_group(grp_t g);
		stats_rd_t r;
		r = '0;
		r.group_id  = g;
		r.min_value = (g == GRP_SIZE) ? 49'h0_0000_FFFF_FFFF : 49'h0_FFFF_FFFF_FFFF;
		r.max_value = (g == GRP_SIZE) ? 49'h0 : 49'h1_0000_0000_0000;
		return r;
	endfunction

	task automatic add_row(cmd_t c, grp_t g, logic [TS_W-1:0] st, logic sp,
			logic [TS_W-1:0] rt, logic rp, logic signed [TS_W-1:0] d,
			logic [SZ_W-1:0] sz, bit typed);
		dir_row_t row;
		row.item  = '{c, g, st, sp, rt, rp, d, sz};
		row.typed = typed;
		row.want  = typed ? fresh_group(g) : '0;
		dir_rows.push_back(row);
	endtask

	// Idle cycles per item, with stretches that run without gaps
	function automatic int idle_draw(inout int run_left, inout bit calm);
		if (run_left == 0) begin
			run_left = $urandom_range(8, 48);
			calm = ($urandom_range(0, 3) == 0);
		end
		run_left--;
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	// Full-range timestamp with the edges mixed in
	function automatic logic [TS_W-1:0] wide_ts();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		2: return 48'h8000_0000_0000;
		3: return 48'h7FFF_FFFF_FFFF;
		default: return w[TS_W-1:0];
		endcase
	endfunction

	// Step a timestamp by a bounded signed amount, reflecting off the range ends
	function automatic logic [TS_W-1:0] walk_ts(logic [TS_W-1:0] prev);
		logic signed [63:0] step;
		logic signed [63:0] nxt;
		step = $signed({32'b0, $urandom_range(0, 32'h10_0000)}) - 64'sd262144;
		nxt = $signed({16'b0, prev}) + step;
		if (nxt < 0 || nxt > TS_TOP)
			nxt = $signed({16'b0, prev}) - step;
		return nxt[TS_W-1:0];
	endfunction

	// Offer one item after the given gap and predict on its transfer
	task automatic send_item(pkt_rec_t it, int gap, bit typed, stats_rd_t want);
		stats_rd_t rd;
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid      <= 1'b1;
		command         <= it.command;
		group_select    <= it.group_select;
		send_time       <= it.send_time;
		send_present    <= it.send_present;
		receive_time    <= it.receive_time;
		receive_present <= it.receive_present;
		one_way_delay   <= it.one_way_delay;
		packet_size     <= it.packet_size;
		do @(posedge clk); while (!item_ready);
		if (stats_apply(it, rd))
			pending_reads.push_back(typed ? want : rd);
	endtask

	// Stop offering and hold until every read result has come back
	task automatic drain_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
	endtask

	function automatic void check_field(string nm, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("%t mismatch on %s: expected %h, got %h", $realtime, nm, want, got);
			mismatches++;
		end
	endfunction

	initial begin : clock_gen
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin : reset_seq
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Drive the directed table, then random traffic
	initial begin : drive_items
		pkt_rec_t it;
		int       gap;
		int       s_run;
		bit       s_calm;
		int       counted;
		int       flood_left;
		int       dly_w;
		bit       wild;
		prev_snd_ts  = '0;
		prev_snd_ok  = 1'b0;
		prev_rcv_ts  = '0;
		prev_rcv_ok  = 1'b0;
		first_snd_ts = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			lo_val[g] = TS_TOP;
			hi_val[g] = TS_BOT;
			lo_pos[g] = '0;
			hi_pos[g] = '0;
			tot[g]    = '0;
			sq_tot[g] = '0;
		end
		lo_val[GRP_SIZE] = {32'b0, SIZE_MIN_RESET};
		hi_val[GRP_SIZE] = '0;
		n_sent     = '0;
		n_recv     = '0;
		lost_bytes = '0;
		s_run  = 0;
		s_calm = 1'b0;

		// reads of untouched groups
		add_row(CMD_READ, GRP_SEND_GAP, '0, 1'b0, '0, 1'b0, '0, '0, 1'b1);
		add_row(CMD_READ, GRP_RECV_GAP, TS_MAX, 1'b0, TS_MAX, 1'b1, '1, '1, 1'b1);
		add_row(CMD_READ, GRP_DELAY, '0, 1'b1, '0, 1'b0, '0, '0, 1'b1);
		add_row(CMD_READ, GRP_SIZE, '0, 1'b0, '0, 1'b0, '0, '0, 1'b1);
		// record without a send time leaves everything as it was
		add_row(CMD_RECORD, GRP_SIZE, TS_MAX, 1'b0, TS_MAX, 1'b1, DLY_MAX, '1, 1'b0);
		add_row(CMD_READ, GRP_SIZE, '0, 1'b0, '0, 1'b0, '0, '0, 1'b1);
		add_row(CMD_READ, GRP_SEND_GAP, '0, 1'b0, '0, 1'b0, '0, '0, 1'b1);
		// first packet: no gaps yet, first send time taken
		add_row(CMD_RECORD, GRP_SEND_GAP, TS_MAX, 1'b1, TS_MAX, 1'b1, -48'sd5, '1, 1'b0);
		add_row(CMD_READ, GRP_SEND_GAP, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0);
		add_row(CMD_READ, GRP_RECV_GAP, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0);
		// negative gaps, a lost packet, equal values that must not move positions
		add_row(CMD_RECORD, GRP_SEND_GAP, TS_MAX - 48'd1000, 1'b1, TS_MAX - 48'd200, 1'b1,
			48'sd300, '0, 1'b0);
		add_row(CMD_RECORD, GRP_SEND_GAP, TS_MAX - 48'd400, 1'b1, '0, 1'b0, DLY_MIN,
			16'd1500, 1'b0);
		add_row(CMD_RECORD, GRP_SEND_GAP, TS_MAX - 48'd390, 1'b1, TS_MAX - 48'd150, 1'b1,
			48'sd12345, 16'd64, 1'b0);
		add_row(CMD_RECORD, GRP_SEND_GAP, TS_MAX - 48'd390, 1'b1, TS_MAX, 1'b0, DLY_MAX,
			'1, 1'b0);
		add_row(CMD_READ, GRP_SEND_GAP, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0);
		add_row(CMD_READ, GRP_RECV_GAP, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0);
		add_row(CMD_READ, GRP_DELAY, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0);
		add_row(CMD_READ, GRP_SIZE, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0);
		add_row(CMD_RECORD, GRP_SEND_GAP, TS_MAX - 48'd100, 1'b1, TS_MAX - 48'd150, 1'b1,
			'0, '0, 1'b0);
		add_row(CMD_RECORD, GRP_SEND_GAP, TS_MAX - 48'd50, 1'b1, TS_MAX - 48'd170, 1'b1,
			-48'sd1, 16'd1, 1'b0);
		add_row(CMD_READ, GRP_RECV_GAP, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0);
		add_row(CMD_READ, GRP_DELAY, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0);
		add_row(CMD_READ, GRP_SEND_GAP, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0);

		wait (arst_n === 1'b1);
		foreach (dir_rows[i])
			send_item(dir_rows[i].item, idle_draw(s_run, s_calm), dir_rows[i].typed,
				dir_rows[i].want);

		// random traffic: moderate walks first, full-range values near the end
		drain_results();
		counted    = 0;
		flood_left = 0;
		while (counted < RAND_ITEMS) begin
			wild = (counted >= WILD_FROM);
			it.command = (flood_left > 0 || $urandom_range(0, 3) == 0) ? CMD_READ : CMD_RECORD;
			it.group_select    = grp_t'($urandom_range(0, 3));
			it.send_present    = ($urandom_range(0, 11) != 0);
			it.receive_present = ($urandom_range(0, 4) != 0);
			it.packet_size     = ($urandom_range(0, 7) == 0) ?
				($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
			if (it.command == CMD_READ) begin
				it.send_time     = wide_ts();
				it.receive_time  = wide_ts();
				it.one_way_delay = wide_ts();
			end else begin
				it.send_time = (wild && $urandom_range(0, 2) == 0) ? wide_ts() :
					walk_ts(prev_snd_ts);
				it.receive_time = (wild && $urandom_range(0, 2) == 0) ? wide_ts() :
					walk_ts(prev_rcv_ts);
				dly_w = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
				it.one_way_delay = (wild && $urandom_range(0, 2) == 0) ? wide_ts() :
					48'(dly_w);
			end
			gap = (flood_left > 0) ? 0 : idle_draw(s_run, s_calm);
			send_item(it, gap, 1'b0, '0);
			if (flood_left > 0)
				flood_left--;
			if (it.command == CMD_READ || it.send_present) begin
				counted++;
				// back-to-back reads while the result side holds off
				if (counted == FLOOD_AT) begin
					@(negedge clk);
					item_valid <= 1'b0;
					hold_req = 1'b1;
					flood_left = FLOOD_ITEMS;
				end
				if (counted == PAUSE_AT)
					drain_results();
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("packet_timing_stats_accumulator verification clean");
		else
			$display("packet_timing_stats_accumulator verification failed");
		$finish;
	end

	// Accept read results with random stalls and check them in order
	initial begin : take_results
		stats_rd_t exp_rd;
		int        stall;
		int        r_run;
		bit        r_calm;
		r_run  = 0;
		r_calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_draw(r_run, r_calm);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				@(negedge clk);
				result_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			result_ready <= 1'b1;
			forever begin
				@(posedge clk);
				if (result_valid)
					break;
				if (hold_req) begin
					hold_req = 1'b0;
					@(negedge clk);
					result_ready <= 1'b0;
					repeat (HOLD_CYCLES - 1) @(negedge clk);
					@(negedge clk);
					result_ready <= 1'b1;
				end
			end
			if (pending_reads.size() == 0) begin
				if (mismatches < 10)
					$display("%t result transfer with nothing pending, group %0d",
						$realtime, group_id);
				mismatches++;
			end else begin
				exp_rd = pending_reads.pop_front();
				check_field("group_id", exp_rd.group_id, group_id);
				check_field("min_value", exp_rd.min_value, min_value);
				check_field("max_value", exp_rd.max_value, max_value);
				check_field("min_position", exp_rd.min_position, min_position);
				check_field("max_position", exp_rd.max_position, max_position);
				check_field("value_sum", exp_rd.value_sum, value_sum);
				check_field("square_sum", exp_rd.square_sum, square_sum);
				check_field("packets_sent", exp_rd.packets_sent, packets_sent);
				check_field("packets_received", exp_rd.packets_received, packets_received);
				check_field("bytes_lost", exp_rd.bytes_lost, bytes_lost);
				check_field("first_send_time", exp_rd.first_send_time, first_send_time);
			end
		end
	end

	// End the run when no transfer happens on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("packet_timing_stats_accumulator verification failed");
		$finish;
	end

endmodule
